>>> design/prf_pkg.sv
// Shared types and constants for the packet ring FIFO.
`default_nettype none

package prf_pkg;

  localparam int SLOT_COUNT_DEF       = 32;
  localparam int MAX_PACKET_BYTES_DEF = 1514;

  // Each slot spans 2048 bytes of the packet store.
  localparam int SPAN_W   = 11;
  localparam int OP_W     = 2;
  localparam int STATUS_W = 3;
  localparam int BYTE_W   = 8;
  localparam int LEN_W    = 11;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH = 2'd0,
    OP_OPEN = 2'd1,
    OP_READ = 2'd2
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 3'd0,
    STAT_EMPTY     = 3'd1,
    STAT_TOO_LONG  = 3'd2,
    STAT_DROP_FULL = 3'd3,
    STAT_DROP_LEN  = 3'd4
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_FETCH
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic push;     // execute a push transfer this cycle
    logic capture;  // latch open/read request fields
    logic finish;   // complete open/read with fetched memory data
    logic pass;     // unknown operation: all-zero result
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

>>> design/prf_if.sv
// Request and response channel interfaces for the packet ring FIFO.
`default_nettype none

interface prf_req_if;
  logic                          valid;
  logic                          ready;
  logic [prf_pkg::OP_W-1:0]      operation;
  logic [prf_pkg::BYTE_W-1:0]    data_byte;
  logic                          last_byte;
  logic [prf_pkg::LEN_W-1:0]     max_length;

  modport source (output valid, output operation, output data_byte, output last_byte,
                  output max_length, input ready);
  modport sink   (input valid, input operation, input data_byte, input last_byte,
                  input max_length, output ready);
endinterface

interface prf_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [prf_pkg::STATUS_W-1:0]  status;
  logic [prf_pkg::BYTE_W-1:0]    read_byte;
  logic                          read_last;
  logic [prf_pkg::LEN_W-1:0]     packet_length;

  modport source (output valid, output status, output read_byte, output read_last,
                  output packet_length, input ready);
  modport sink   (input valid, input status, input read_byte, input read_last,
                  input packet_length, output ready);
endinterface

`default_nettype wire

>>> design/prf_ctrl.sv
// Controller state machine: accepts requests and sequences memory fetches.
`default_nettype none

module prf_ctrl (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      req_valid,
  input  wire logic [prf_pkg::OP_W-1:0]  req_op,
  input  wire prf_pkg::stat_t            stat,
  output prf_pkg::cmd_t                  cmd,
  output logic                           req_ready
);
  import prf_pkg::*;

  state_t state;
  state_t state_next;
  logic   accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    accept     = 1'b0;
    case (state)
      S_IDLE: begin
        req_ready = stat.out_free;
        accept    = req_valid && stat.out_free;
        if (accept) begin
          case (op_t'(req_op))
            OP_PUSH: cmd.push = 1'b1;
            OP_OPEN, OP_READ: begin
              cmd.capture = 1'b1;
              state_next  = S_FETCH;
            end
            default: cmd.pass = 1'b1;
          endcase
        end
      end
      S_FETCH: begin
        // registered memory reads are valid now
        cmd.finish = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

>>> design/prf_dpath.sv
// Datapath: ring pointers, packet and length stores, result register.
`default_nettype none

module prf_dpath #(
  parameter int SLOT_COUNT       = prf_pkg::SLOT_COUNT_DEF,
  parameter int MAX_PACKET_BYTES = prf_pkg::MAX_PACKET_BYTES_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire prf_pkg::cmd_t              cmd,
  input  wire logic [prf_pkg::OP_W-1:0]   req_op,
  input  wire logic [prf_pkg::BYTE_W-1:0] req_data,
  input  wire logic                       req_last,
  input  wire logic [prf_pkg::LEN_W-1:0]  req_limit,
  output prf_pkg::stat_t                  stat,
  prf_rsp_if.source                       rsp
);
  import prf_pkg::*;

  localparam int SLOT_W = $clog2(SLOT_COUNT);
  localparam int OFF_W  = $clog2(MAX_PACKET_BYTES + 1);
  localparam int ADDR_W = SLOT_W + SPAN_W;
  localparam int DEPTH  = SLOT_COUNT * (2 ** SPAN_W);
  localparam int CMP_W  = (OFF_W > LEN_W) ? OFF_W : LEN_W;

  logic [BYTE_W-1:0] store [DEPTH];
  logic [OFF_W-1:0]  len_mem [SLOT_COUNT];

  logic [SLOT_W-1:0] write_slot, read_slot;
  logic [OFF_W-1:0]  write_offset, read_offset;
  logic              push_overflow;
  op_t               op_q;
  logic [LEN_W-1:0]  limit_q;
  logic [BYTE_W-1:0] store_q;
  logic [OFF_W-1:0]  len_q;

  logic              out_valid;
  status_t           out_status;
  logic [BYTE_W-1:0] out_byte;
  logic              out_last;
  logic [LEN_W-1:0]  out_len;

  // push path
  logic              store_ok;
  logic [OFF_W-1:0]  wo_inc;
  logic              ovf;
  logic [SLOT_W-1:0] wslot_inc;
  logic              commit;
  status_t           push_status;
  logic [ADDR_W-1:0] waddr;
  logic [ADDR_W-1:0] raddr;

  // fetch path
  logic              empty;
  logic [SLOT_W-1:0] rslot_inc;
  logic              end_of_pkt;
  logic              too_long;

  assign store_ok  = write_offset < OFF_W'(MAX_PACKET_BYTES);
  assign wo_inc    = store_ok ? write_offset + 1'b1 : write_offset;
  assign ovf       = push_overflow || !store_ok;
  assign wslot_inc = (write_slot == SLOT_W'(SLOT_COUNT - 1)) ? '0 : write_slot + 1'b1;
  assign rslot_inc = (read_slot == SLOT_W'(SLOT_COUNT - 1)) ? '0 : read_slot + 1'b1;
  assign waddr     = {write_slot, write_offset[SPAN_W-1:0]};
  assign raddr     = {read_slot, read_offset[SPAN_W-1:0]};

  always_comb begin
    commit      = 1'b0;
    push_status = STAT_OK;
    if (req_last) begin
      if (ovf || wo_inc == '0) begin
        push_status = STAT_DROP_LEN;
      end else if (wslot_inc == read_slot) begin
        push_status = STAT_DROP_FULL;
      end else begin
        commit = 1'b1;
      end
    end
  end

  assign empty      = read_slot == write_slot;
  assign end_of_pkt = ({1'b0, read_offset} + 1'b1) >= {1'b0, len_q};
  assign too_long   = CMP_W'(limit_q) < CMP_W'(len_q);

  // Memories: one write port, registered read at the current read pointers
  always_ff @(posedge clk) begin
    if (cmd.push && store_ok) begin
      store[waddr] <= req_data;
    end
    store_q <= store[raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.push && commit) begin
      len_mem[write_slot] <= wo_inc;
    end
    len_q <= len_mem[read_slot];
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q    <= op_t'(req_op);
      limit_q <= req_limit;
    end
  end

  // Ring pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      write_slot    <= '0;
      read_slot     <= '0;
      write_offset  <= '0;
      read_offset   <= '0;
      push_overflow <= 1'b0;
    end else begin
      if (cmd.push) begin
        if (req_last) begin
          write_offset  <= '0;
          push_overflow <= 1'b0;
          if (commit) begin
            write_slot <= wslot_inc;
          end
        end else begin
          write_offset  <= wo_inc;
          push_overflow <= ovf;
        end
      end
      if (cmd.finish) begin
        if (op_q == OP_OPEN) begin
          read_offset <= '0;
        end else if (!empty) begin
          if (end_of_pkt) begin
            read_offset <= '0;
            read_slot   <= rslot_inc;
          end else begin
            read_offset <= read_offset + 1'b1;
          end
        end
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.push || cmd.pass || cmd.finish) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push || cmd.pass || cmd.finish) begin
      out_status <= STAT_OK;
      out_byte   <= '0;
      out_last   <= 1'b0;
      out_len    <= '0;
      if (cmd.push) begin
        out_status <= push_status;
      end else if (cmd.finish) begin
        if (empty) begin
          out_status <= STAT_EMPTY;
        end else if (op_q == OP_OPEN) begin
          out_len    <= LEN_W'(len_q);
          out_status <= too_long ? STAT_TOO_LONG : STAT_OK;
        end else begin
          out_byte <= store_q;
          out_last <= end_of_pkt;
        end
      end
    end
  end

  assign stat.out_free     = !out_valid || rsp.ready;
  assign rsp.valid         = out_valid;
  assign rsp.status        = out_status;
  assign rsp.read_byte     = out_byte;
  assign rsp.read_last     = out_last;
  assign rsp.packet_length = out_len;

endmodule

`default_nettype wire

>>> design/packet_ring_fifo.sv
// Top level of the packet ring FIFO: controller, datapath and checks.
//
//  channel  dir  payload                                          handshake
//  req      in   operation, data_byte, last_byte, max_length      valid/ready
//  rsp      out  status, read_byte, read_last, packet_length      valid/ready
//
// Push and unknown ops go straight to the result register; open and read wait
// in the fetch state for the registered reads of the packet and length stores.
// One request is in flight at a time; req.ready drops while a fetch is pending
// or the result register holds a result that rsp.ready does not take.
// Reset clears pointers, out_valid and state; stores need no clearing pass.
`default_nettype none

module packet_ring_fifo #(
  parameter int SLOT_COUNT       = prf_pkg::SLOT_COUNT_DEF,
  parameter int MAX_PACKET_BYTES = prf_pkg::MAX_PACKET_BYTES_DEF
) (
  input wire logic  clk,
  input wire logic  rst,
  prf_req_if.sink   req,
  prf_rsp_if.source rsp
);
  import prf_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  prf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_op    (req.operation),
    .stat      (stat),
    .cmd       (cmd),
    .req_ready (req.ready)
  );

  prf_dpath #(
    .SLOT_COUNT       (SLOT_COUNT),
    .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .req_op    (req.operation),
    .req_data  (req.data_byte),
    .req_last  (req.last_byte),
    .req_limit (req.max_length),
    .stat      (stat),
    .rsp       (rsp)
  );

`ifndef SYNTHESIS
  a_fetch_two_cycles: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready &&
    (req.operation == OP_OPEN || req.operation == OP_READ)
    |=> !rsp.valid ##1 rsp.valid)
    else $error("open/read transfer did not produce a result after the fetch");

  a_push_one_cycle: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready && req.operation != OP_OPEN && req.operation != OP_READ
    |=> rsp.valid)
    else $error("push transfer did not produce a result on the next cycle");

  a_last_is_ok: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.read_last |-> rsp.status == STAT_OK && rsp.packet_length == '0)
    else $error("end of packet flagged on a non-ok result");

  a_single_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.push, cmd.capture, cmd.finish, cmd.pass}))
    else $error("controller issued more than one command");
`endif

endmodule

`default_nettype wire

>>> tb/packet_ring_fifo_tb.sv
// Self-checking testbench for the packet ring FIFO: directed cases, then random packet traffic.
`default_nettype none

module packet_ring_fifo_tb;
  import prf_pkg::*;

  localparam int SLOTS     = SLOT_COUNT_DEF;
  localparam int MAX_BYTES = MAX_PACKET_BYTES_DEF;
  localparam int SLOT_SPAN = 2048;
  localparam int RANDOM_ITEMS = 1150;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    status_t           status;
    logic [BYTE_W-1:0] rbyte;
    logic              rlast;
    logic [LEN_W-1:0]  plen;
  } ring_result_t;

  // Tracks the ring as the block should see it and holds the results still owed.
  class ring_fifo_scoreboard;
    logic [BYTE_W-1:0] slot_bytes [SLOTS*SLOT_SPAN];
    logic [LEN_W-1:0]  slot_len [SLOTS];
    int unsigned       wr_slot, rd_slot, wr_off, rd_off;
    bit                overflow;
    ring_result_t      owed_q[$];
    int mismatches, strays, reported, accepted;
    int commits, drops_full, drops_len, too_long, empties;

    function new();
      wr_slot = 0;
      rd_slot = 0;
      wr_off = 0;
      rd_off = 0;
      overflow = 0;
    endfunction

    function void note_request(logic [OP_W-1:0] op, logic [BYTE_W-1:0] data, logic last,
                               logic [LEN_W-1:0] limit);
      ring_result_t res;
      int unsigned  nxt;
      logic [LEN_W-1:0] len;
      res = '0;
      accepted++;
      case (op)
        OP_PUSH: begin
          if (wr_off < MAX_BYTES) begin
            slot_bytes[wr_slot*SLOT_SPAN + wr_off] = data;
            wr_off++;
          end else begin
            overflow = 1'b1;
          end
          if (last) begin
            nxt = (wr_slot + 1) % SLOTS;
            if (overflow || wr_off == 0) begin
              res.status = STAT_DROP_LEN;
              drops_len++;
            end else if (nxt == rd_slot) begin
              res.status = STAT_DROP_FULL;
              drops_full++;
            end else begin
              slot_len[wr_slot] = LEN_W'(wr_off);
              wr_slot = nxt;
              commits++;
            end
            wr_off = 0;
            overflow = 1'b0;
          end
        end
        OP_OPEN: begin
          rd_off = 0;
          if (rd_slot == wr_slot) begin
            res.status = STAT_EMPTY;
            empties++;
          end else begin
            len = slot_len[rd_slot];
            res.plen = len;
            if (limit < len) begin
              res.status = STAT_TOO_LONG;
              too_long++;
            end
          end
        end
        OP_READ: begin
          if (rd_slot == wr_slot) begin
            res.status = STAT_EMPTY;
            empties++;
          end else begin
            res.rbyte = slot_bytes[rd_slot*SLOT_SPAN + rd_off];
            if (rd_off + 1 >= slot_len[rd_slot]) begin
              res.rlast = 1'b1;
              rd_off = 0;
              rd_slot = (rd_slot + 1) % SLOTS;
            end else begin
              rd_off++;
            end
          end
        end
        default: ;
      endcase
      owed_q.push_back(res);
    endfunction

    function void check_response(logic [STATUS_W-1:0] st, logic [BYTE_W-1:0] rbyte,
                                 logic rlast, logic [LEN_W-1:0] plen);
      ring_result_t exp;
      if (owed_q.size() == 0) begin
        strays++;
        if (reported < 10) begin
          $display("unexpected result: st=%0d byte=%02h last=%0d len=%0d",
                   st, rbyte, rlast, plen);
          reported++;
        end
      end else begin
        exp = owed_q.pop_front();
        if (exp.status !== st || exp.rbyte !== rbyte || exp.rlast !== rlast ||
            exp.plen !== plen) begin
          mismatches++;
          if (reported < 10) begin
            $display("mismatch: exp st=%0d byte=%02h last=%0d len=%0d,",
                     exp.status, exp.rbyte, exp.rlast, exp.plen);
            $display("          got st=%0d byte=%02h last=%0d len=%0d",
                     st, rbyte, rlast, plen);
            reported++;
          end
        end
      end
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    function int front_length();
      return (rd_slot == wr_slot) ? 0 : int'(slot_len[rd_slot]);
    endfunction

    function int front_remaining();
      return (rd_slot == wr_slot) ? 0 : int'(slot_len[rd_slot]) - int'(rd_off);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  prf_req_if req_ch ();
  prf_rsp_if rsp_ch ();

  packet_ring_fifo u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  ring_fifo_scoreboard sb;
  int work_items;
  int src_calm, sink_calm, stall_left;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    if (src_calm > 0) begin
      src_calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      src_calm = $urandom_range(30, 150);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic pick_ready();
    int r;
    if (stall_left > 0) begin
      stall_left--;
      return 1'b0;
    end
    if (sink_calm > 0) begin
      sink_calm--;
      return 1'b1;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      sink_calm = $urandom_range(30, 150);
      return 1'b1;
    end
    if (r < 70) return 1'b1;
    if (r < 95) stall_left = $urandom_range(0, 2);
    else stall_left = $urandom_range(8, 40);
    return 1'b0;
  endfunction

  // Result side: check each transfer, then pick the next ready value.
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
      sb.check_response(rsp_ch.status, rsp_ch.read_byte, rsp_ch.read_last,
                        rsp_ch.packet_length);
    rsp_ch.ready <= rst ? 1'b0 : pick_ready();
  end

  task automatic send_item(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] data,
                           input logic last, input logic [LEN_W-1:0] limit);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.operation  <= op;
    req_ch.data_byte  <= data;
    req_ch.last_byte  <= last;
    req_ch.max_length <= limit;
    @(posedge clk);
    while (req_ch.ready !== 1'b1) @(posedge clk);
    sb.note_request(op, data, last, limit);
    if (op != OP_UNUSED) work_items++;
  endtask

  task automatic push_packet(input int len);
    for (int i = 0; i < len; i++)
      send_item(OP_PUSH, BYTE_W'($urandom_range(0, 255)), i == len - 1,
                LEN_W'($urandom_range(0, 2047)));
  endtask

  task automatic send_open(input logic [LEN_W-1:0] limit);
    send_item(OP_OPEN, BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), limit);
  endtask

  task automatic send_reads(input int n);
    repeat (n) send_item(OP_READ, BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                         LEN_W'($urandom_range(0, 2047)));
  endtask

  // Optionally open the oldest packet, then read out whatever is left of it.
  task automatic read_whole();
    int q, len, rem;
    q = $urandom_range(0, 9);
    len = sb.front_length();
    if (q < 5) send_open(LEN_W'($urandom_range(len, 2047)));
    else if (q < 7)
      send_open(LEN_W'(len > 0 ? $urandom_range(0, len - 1) : $urandom_range(0, 2047)));
    rem = sb.front_remaining();
    send_reads(rem == 0 ? 1 : rem);
  endtask

  task automatic read_partial();
    int rem;
    send_open(LEN_W'($urandom_range(0, 2047)));
    rem = sb.front_remaining();
    send_reads(rem == 0 ? 1 : $urandom_range(1, rem));
  endtask

  function automatic int pick_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(1, 8);
    if (r < 92) return $urandom_range(9, 64);
    return $urandom_range(65, 300);
  endfunction

  initial begin
    int r, q, push_share;
    sb = new();
    rst = 1'b1;
    req_ch.valid      = 1'b0;
    req_ch.operation  = OP_PUSH;
    req_ch.data_byte  = '0;
    req_ch.last_byte  = 1'b0;
    req_ch.max_length = '0;
    rsp_ch.ready      = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // empty ring and unknown operation
    send_open(11'h7ff);
    send_reads(1);
    send_item(OP_UNUSED, 8'hff, 1'b1, 11'h7ff);
    // one-byte and two-byte packets, byte extremes
    send_item(OP_PUSH, 8'h00, 1'b1, 11'h000);
    send_item(OP_PUSH, 8'hff, 1'b0, 11'h7ff);
    send_item(OP_PUSH, 8'ha5, 1'b1, 11'h000);
    send_open(11'd0);
    send_open(11'd1);
    send_reads(1);
    // read with no open, then reopen to restart the packet
    send_reads(1);
    send_open(11'h7ff);
    send_reads(2);
    send_reads(1);
    // longest packet that fits, then one that overflows
    push_packet(MAX_BYTES);
    send_open(LEN_W'(MAX_BYTES - 1));
    send_open(LEN_W'(MAX_BYTES));
    send_reads(MAX_BYTES);
    push_packet(MAX_BYTES + 1);
    send_open(11'h7ff);
    // fill the ring to one free slot, then overrun it
    for (int i = 0; i < SLOTS - 1; i++) push_packet($urandom_range(1, 3));
    push_packet(2);
    for (int i = 0; i < SLOTS - 1; i++) read_whole();

    // hold off until everything owed has come back
    req_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);

    work_items = 0;
    while (work_items < RANDOM_ITEMS) begin
      push_share = ((work_items / 200) % 2 == 0) ? 60 : 30;
      r = $urandom_range(0, 99);
      q = $urandom_range(0, 99);
      if (r < push_share) push_packet(pick_length());
      else if (q < 65) read_whole();
      else if (q < 85) read_partial();
      else begin
        repeat ($urandom_range(1, 4))
          send_item(OP_W'($urandom_range(0, 3)), BYTE_W'($urandom_range(0, 255)),
                    1'($urandom_range(0, 1)), LEN_W'($urandom_range(0, 2047)));
      end
    end

    req_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("%0d requests checked: %0d packets committed, %0d dropped on a full ring,",
             sb.accepted, sb.commits, sb.drops_full);
    $display("%0d dropped as too long, %0d opens over the caller limit, %0d empty accesses",
             sb.drops_len, sb.too_long, sb.empties);
    $display("%0d mismatches, %0d strays", sb.mismatches, sb.strays);
    if (sb.mismatches == 0 && sb.strays == 0 && sb.pending() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

  initial begin
    #20000000;
    $display("FAILURE");
    $finish;
  end

endmodule

`default_nettype wire
